// File: src/leib_pkg.sv
// ----------------------------------------------------------------------------
// leib_pkg - shared definitions for the line editing input buffer
// Sizes, character codes, result kinds, controller states and the result
// item type used by the controller and the output stage.
// ----------------------------------------------------------------------------
package leib_pkg;

    // Storage and read sizes
    localparam int LINE_DEPTH = 256;
    localparam int MAX_READ   = 32;
    localparam int ADDR_W     = $clog2(LINE_DEPTH);
    localparam int POS_W      = ADDR_W + 1;
    localparam int CNT_W      = 6;
    localparam int SUM_W      = (POS_W > CNT_W) ? POS_W : CNT_W;

    // Character codes
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;

    // Input item kinds
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // Result item kinds
    localparam logic [1:0] OK_ECHO  = 2'd0;
    localparam logic [1:0] OK_DATA  = 2'd1;
    localparam logic [1:0] OK_EMPTY = 2'd2;

    // Controller states
    typedef enum logic [0:0] {
        S_IDLE,
        S_READ
    } state_t;

    // One result item
    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       data;
        logic             last;
        logic [CNT_W-1:0] delivered;
    } out_item_t;

endpackage

// File: src/leib_out_stage.sv
// ----------------------------------------------------------------------------
// leib_out_stage - registered result stage
// Holds one result item for the master side and takes a new one whenever
// the held item is gone or leaves in the same cycle.
// ----------------------------------------------------------------------------
module leib_out_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  leib_pkg::out_item_t in_item,
    output logic                in_ready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata,   // [7:0] out_byte, [13:8] delivered, [15:14] zero
    output logic [1:0]          m_tuser,   // [1:0] out_kind
    output logic                m_tlast    // last result of the input transfer
);
    import leib_pkg::*;

    logic      valid_reg;
    out_item_t item_reg;

    assign in_ready = !valid_reg || m_tready;

    // Valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= in_item;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(16 - 8 - CNT_W){1'b0}}, item_reg.delivered, item_reg.data};
    assign m_tuser  = item_reg.kind;
    assign m_tlast  = item_reg.last;

endmodule

// File: src/line_editing_input_buffer_top.sv
// ----------------------------------------------------------------------------
// line_editing_input_buffer_top - canonical terminal line buffer
// Stores and echoes typed characters, handles backspace and newline, and
// answers read requests with bytes of the completed line.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one transfer per typed character (s_tuser = 0) or read
//   request (s_tuser = 1). s_tdata carries char_in in [7:0] and read_count
//   in [13:8].
//   Master channel: result transfers; m_tuser is the result kind (echo, read
//   data, read finished empty), m_tdata carries the byte and the delivered
//   count, m_tlast marks the last result of one input transfer.
//   The echo of a character appears in the cycle after it is taken. A read
//   holds the slave side while it runs: the request is taken, the first byte
//   is fetched from the line store, then one byte per cycle follows from the
//   single read port of the line store while the receiver keeps taking them.
//   A read that arrives before the line is complete is held and served when
//   the newline comes in, right after the newline echo.
//   Reset empties the line and drops a waiting read; the line store itself
//   is not cleared, only bytes written for the current line are read.
//   When the receiver stalls, the result register holds its item and the
//   slave side stops taking transfers until results can move again.
// ----------------------------------------------------------------------------
module line_editing_input_buffer_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] char_in, [13:8] read_count, [15:14] zero
    input  logic        s_tuser,   // [0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [13:8] delivered, [15:14] zero
    output logic [1:0]  m_tuser,   // [1:0] out_kind
    output logic        m_tlast    // last result of the input transfer
);
    import leib_pkg::*;

    // Controller state
    state_t           state_reg,      state_next;
    logic [POS_W-1:0] edit_pos_reg,   edit_pos_next;
    logic [POS_W-1:0] line_len_reg,   line_len_next;
    logic [POS_W-1:0] read_pos_reg,   read_pos_next;
    logic             line_ready_reg, line_ready_next;
    logic             read_wait_reg,  read_wait_next;
    logic [CNT_W-1:0] wait_cnt_reg,   wait_cnt_next;
    logic [CNT_W-1:0] n_reg,          n_next;
    logic [CNT_W-1:0] idx_reg,        idx_next;
    logic             pend_reg,       pend_next;

    // Line store
    logic [7:0]        line_mem [LINE_DEPTH];
    logic [7:0]        rd_data_reg;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;

    // Result path
    logic      o_valid;
    logic      o_ready;
    out_item_t o_item;

    // Input fields
    logic             in_kind;
    logic [7:0]       in_char;
    logic [CNT_W-1:0] in_cnt;
    logic [CNT_W-1:0] cnt_sat;
    logic [POS_W-1:0] avail;
    logic [CNT_W-1:0] serve_n;
    logic [CNT_W-1:0] idx_inc;
    logic [POS_W-1:0] pos_sum;

    assign in_kind = s_tuser;
    assign in_char = s_tdata[7:0];
    assign in_cnt  = s_tdata[8 +: CNT_W];

    assign s_tready = (state_reg == S_IDLE) && o_ready;

    // Saturated count and bytes a served read delivers
    always_comb begin
        cnt_sat = (in_cnt > CNT_W'(MAX_READ)) ? CNT_W'(MAX_READ) : in_cnt;
        avail   = line_len_reg - read_pos_reg;
        serve_n = (SUM_W'(cnt_sat) < SUM_W'(avail)) ? cnt_sat : CNT_W'(avail);
        idx_inc = idx_reg + CNT_W'(1);
        pos_sum = read_pos_reg + POS_W'(n_reg);
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            edit_pos_reg   <= '0;
            line_len_reg   <= '0;
            read_pos_reg   <= '0;
            line_ready_reg <= 1'b0;
            read_wait_reg  <= 1'b0;
            wait_cnt_reg   <= '0;
            n_reg          <= '0;
            idx_reg        <= '0;
            pend_reg       <= 1'b0;
        end else begin
            state_reg      <= state_next;
            edit_pos_reg   <= edit_pos_next;
            line_len_reg   <= line_len_next;
            read_pos_reg   <= read_pos_next;
            line_ready_reg <= line_ready_next;
            read_wait_reg  <= read_wait_next;
            wait_cnt_reg   <= wait_cnt_next;
            n_reg          <= n_next;
            idx_reg        <= idx_next;
            pend_reg       <= pend_next;
        end
    end

    // Next state, line store access and results
    always_comb begin
        state_next      = state_reg;
        edit_pos_next   = edit_pos_reg;
        line_len_next   = line_len_reg;
        read_pos_next   = read_pos_reg;
        line_ready_next = line_ready_reg;
        read_wait_next  = read_wait_reg;
        wait_cnt_next   = wait_cnt_reg;
        n_next          = n_reg;
        idx_next        = idx_reg;
        pend_next       = pend_reg;
        wr_en           = 1'b0;
        wr_addr         = edit_pos_reg[ADDR_W-1:0];
        wr_data         = in_char;
        rd_en           = 1'b0;
        rd_addr         = ADDR_W'(read_pos_reg + POS_W'(idx_reg));
        o_valid         = 1'b0;
        o_item.kind      = OK_ECHO;
        o_item.data      = in_char;
        o_item.last      = 1'b1;
        o_item.delivered = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    if (in_kind == KIND_READ) begin
                        if (line_ready_reg) begin
                            // Serve the read from the completed line
                            n_next     = serve_n;
                            idx_next   = '0;
                            pend_next  = 1'b0;
                            state_next = S_READ;
                        end else begin
                            read_wait_next = 1'b1;
                            wait_cnt_next  = cnt_sat;
                        end
                    end else if (in_char == CH_NUL || line_ready_reg) begin
                        // ignored or dropped
                    end else if (in_char == CH_LF || in_char == CH_CR) begin
                        if (SUM_W'(edit_pos_reg) < SUM_W'(LINE_DEPTH)) begin
                            // Complete the line
                            wr_en           = 1'b1;
                            wr_data         = CH_LF;
                            edit_pos_next   = edit_pos_reg + POS_W'(1);
                            line_len_next   = edit_pos_reg + POS_W'(1);
                            read_pos_next   = '0;
                            line_ready_next = 1'b1;
                            o_valid         = 1'b1;
                            o_item.data     = CH_LF;
                            if (read_wait_reg) begin
                                // Waiting read follows the echo
                                o_item.last    = 1'b0;
                                read_wait_next = 1'b0;
                                wait_cnt_next  = '0;
                                n_next = (SUM_W'(wait_cnt_reg) < SUM_W'(edit_pos_reg) + SUM_W'(1))
                                       ? wait_cnt_reg
                                       : CNT_W'(edit_pos_reg + POS_W'(1));
                                idx_next   = '0;
                                pend_next  = 1'b0;
                                state_next = S_READ;
                            end
                        end
                    end else if (in_char == CH_BS) begin
                        if (edit_pos_reg != '0) begin
                            edit_pos_next = edit_pos_reg - POS_W'(1);
                            o_valid       = 1'b1;
                        end
                    end else if (SUM_W'(edit_pos_reg) + SUM_W'(1) < SUM_W'(LINE_DEPTH)) begin
                        // Ordinary character
                        wr_en         = 1'b1;
                        edit_pos_next = edit_pos_reg + POS_W'(1);
                        o_valid       = 1'b1;
                    end
                end
            end
            S_READ: begin
                if (n_reg == '0) begin
                    // Empty read: one completion result, line kept
                    o_item.kind = OK_EMPTY;
                    o_item.data = '0;
                    o_valid     = 1'b1;
                    if (o_ready) begin
                        state_next = S_IDLE;
                    end
                end else if (!pend_reg) begin
                    // Fetch the first byte
                    rd_en     = 1'b1;
                    pend_next = 1'b1;
                end else begin
                    o_item.kind      = OK_DATA;
                    o_item.data      = rd_data_reg;
                    o_item.delivered = n_reg;
                    o_item.last      = (idx_inc == n_reg);
                    o_valid          = 1'b1;
                    if (o_ready) begin
                        if (idx_inc == n_reg) begin
                            // Read done: advance, restart editing when drained
                            pend_next     = 1'b0;
                            state_next    = S_IDLE;
                            read_pos_next = pos_sum;
                            if (pos_sum >= line_len_reg) begin
                                line_ready_next = 1'b0;
                                edit_pos_next   = '0;
                                line_len_next   = '0;
                                read_pos_next   = '0;
                            end
                        end else begin
                            // Fetch the next byte while this one leaves
                            idx_next = idx_inc;
                            rd_en    = 1'b1;
                            rd_addr  = ADDR_W'(read_pos_reg + POS_W'(idx_inc));
                        end
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Line store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= line_mem[rd_addr];
        end
    end

    // Result register toward the master side
    leib_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (o_valid),
        .in_item  (o_item),
        .in_ready (o_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// File: tb/line_editing_input_buffer_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_editing_input_buffer_checker - result checker for the line buffer
// Watches both stream channels. Every input transfer is run through a model
// of the canonical line discipline, which queues the echo and read results
// it should cause. Every result transfer is compared field by field with
// the oldest queued result.
// ----------------------------------------------------------------------------
module line_editing_input_buffer_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] char_in, [13:8] read_count, [15:14] zero
    input  logic        s_tuser,   // [0] kind
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // [7:0] out_byte, [13:8] delivered, [15:14] zero
    input  logic [1:0]  m_tuser,   // [1:0] out_kind
    input  logic        m_tlast,
    output int          mismatch_count,
    output int          results_owed
);
    import leib_pkg::*;

    // Model of the line discipline state
    logic [7:0]  line_mem [LINE_DEPTH];
    int unsigned edit_pos;
    int unsigned line_len;
    int unsigned rd_pos;
    bit          line_done;
    bit          rd_pending;
    int unsigned rd_pending_cnt;

    // Echo and read results still to come, oldest first
    out_item_t   tty_results_q[$];

    task automatic report_mismatch(input string msg);
        $display("%0t ns: MISMATCH %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic push_result(input logic [1:0] kind, input logic [7:0] data,
                               input int unsigned dlv);
        out_item_t item;
        item.kind      = kind;
        item.data      = data;
        item.last      = 1'b0;
        item.delivered = dlv[CNT_W-1:0];
        tty_results_q.push_back(item);
    endtask

    // Hand out min(count, unread) bytes; a fully read line restarts editing
    task automatic serve_line_read(input int unsigned cnt);
        int unsigned avail;
        int unsigned n;
        int unsigned i;
        avail = line_len - rd_pos;
        n     = (cnt < avail) ? cnt : avail;
        if (n == 0) begin
            push_result(OK_EMPTY, 8'h00, 0);
        end else begin
            for (i = 0; i < n; i++)
                push_result(OK_DATA, line_mem[rd_pos + i], n);
            rd_pos += n;
            if (rd_pos >= line_len) begin
                line_done = 1'b0;
                edit_pos  = 0;
                line_len  = 0;
                rd_pos    = 0;
            end
        end
    endtask

    // One input transfer: update the model and queue what it causes
    task automatic line_discipline_step(input logic kind, input logic [7:0] ch,
                                        input logic [CNT_W-1:0] cnt_raw);
        int unsigned cnt;
        int          start_sz;
        out_item_t   tail;
        start_sz = tty_results_q.size();
        cnt      = (cnt_raw > MAX_READ) ? MAX_READ : cnt_raw;
        if (kind == KIND_READ) begin
            if (line_done) begin
                serve_line_read(cnt);
            end else begin
                // newest waiting read wins
                rd_pending     = 1'b1;
                rd_pending_cnt = cnt;
            end
        end else if (ch == CH_NUL || line_done) begin
            // ignored, or dropped while a line is unread
        end else if (ch == CH_LF || ch == CH_CR) begin
            if (edit_pos < LINE_DEPTH) begin
                line_mem[edit_pos] = CH_LF;
                edit_pos++;
                line_len  = edit_pos;
                rd_pos    = 0;
                line_done = 1'b1;
                push_result(OK_ECHO, CH_LF, 0);
                if (rd_pending) begin
                    rd_pending = 1'b0;
                    serve_line_read(rd_pending_cnt);
                    rd_pending_cnt = 0;
                end
            end
        end else if (ch == CH_BS) begin
            if (edit_pos > 0) begin
                edit_pos--;
                push_result(OK_ECHO, CH_BS, 0);
            end
        end else if (edit_pos + 1 < LINE_DEPTH) begin
            // last slot is kept free for the newline
            line_mem[edit_pos] = ch;
            edit_pos++;
            push_result(OK_ECHO, ch, 0);
        end
        if (tty_results_q.size() > start_sz) begin
            tail      = tty_results_q.pop_back();
            tail.last = 1'b1;
            tty_results_q.push_back(tail);
        end
    endtask

    // Predict on input transfers first, then check result transfers
    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            edit_pos       = 0;
            line_len       = 0;
            rd_pos         = 0;
            line_done      = 1'b0;
            rd_pending     = 1'b0;
            rd_pending_cnt = 0;
            mismatch_count = 0;
            tty_results_q.delete();
        end else begin
            if (s_tvalid && s_tready)
                line_discipline_step(s_tuser, s_tdata[7:0], s_tdata[13:8]);
            if (m_tvalid && m_tready) begin
                if (tty_results_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result kind %0d byte %02h last %0b",
                                              m_tuser, m_tdata[7:0], m_tlast));
                end else begin
                    want = tty_results_q.pop_front();
                    if (m_tuser !== want.kind || m_tdata[7:0] !== want.data ||
                        m_tlast !== want.last || m_tdata[13:8] !== want.delivered)
                        report_mismatch($sformatf(
                            "kind %0d/%0d byte %02h/%02h last %0b/%0b dlv %0d/%0d (got/exp)",
                            m_tuser, want.kind, m_tdata[7:0], want.data,
                            m_tlast, want.last, m_tdata[13:8], want.delivered));
                end
            end
        end
        results_owed <= tty_results_q.size();
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - testbench for the line editing input buffer
// Sends typed characters and read requests in bursts with random gaps while
// the result side stalls on changing patterns. A directed part covers
// backspace, ignored and dropped bytes, empty and saturated reads and
// waiting reads; a full-line pass fills the line store; the rest are random
// typed lines with random reads and some noise.
// ----------------------------------------------------------------------------
module tb;
    import leib_pkg::*;

    typedef enum int unsigned {
        RX_ALWAYS,
        RX_RANDOM,
        RX_SPARSE,
        RX_PERIODIC
    } rx_mode_t;

    localparam int ITEM_TARGET  = 450;
    localparam int DRAIN_LIMIT  = 50000;
    localparam int TAIL_CYCLES  = 40;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    int          mismatch_count;
    int          results_owed;

    int unsigned burst_left = 0;
    bit          nogap_mode = 1'b0;
    int unsigned items_sent = 0;

    rx_mode_t    rx_mode    = RX_ALWAYS;
    int unsigned rx_left    = 0;
    int unsigned rx_phase   = 0;

    line_editing_input_buffer_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    line_editing_input_buffer_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Hard stop
    initial begin
        #15_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // Receiver stall patterns, each held for a random stretch
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(40, 400);
        end
        rx_left--;
        rx_phase++;
        case (rx_mode)
            RX_ALWAYS:   m_tready <= 1'b1;
            RX_RANDOM:   m_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE:   m_tready <= ($urandom_range(0, 3) == 0);
            default:     m_tready <= ((rx_phase % 7) < 3);
        endcase
    end

    // One input transfer, with a random gap at the start of each burst
    task automatic send_item(input logic kind, input logic [7:0] ch,
                             input logic [5:0] cnt);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = nogap_mode ? 0 : $urandom_range(0, 7);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {2'b00, cnt, ch};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // Typed byte; the unused count field carries noise
    task automatic send_char(input logic [7:0] ch);
        send_item(KIND_CHAR, ch, 6'($urandom_range(0, 63)));
    endtask

    // Read request; the unused byte field carries noise
    task automatic send_read(input logic [5:0] cnt);
        send_item(KIND_READ, 8'($urandom_range(0, 255)), cnt);
    endtask

    // Ordinary character: anything but NUL, backspace and line ends
    function automatic logic [7:0] random_plain_char();
        logic [7:0] c;
        do begin
            if ($urandom_range(0, 3) == 0)
                c = 8'($urandom_range(1, 255));
            else
                c = 8'($urandom_range(8'h20, 8'h7e));
        end while (c == CH_BS || c == CH_LF || c == CH_CR);
        return c;
    endfunction

    // Stimulus and verdict
    initial begin
        int unsigned line_chars;
        int unsigned remaining;
        int unsigned take;
        int unsigned r;
        int unsigned early_cnt;
        bit          early;
        logic [5:0]  cnt;
        int          guard;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = KIND_CHAR;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: waiting empty read, edits, drops, empty and saturated reads
        send_read(6'd0);
        send_char("A");
        send_char(CH_NUL);
        send_char(CH_BS);
        send_char(CH_BS);             // backspace on empty line
        send_char(8'hff);
        send_char(8'h01);
        send_char(8'h80);
        send_char("x");
        send_char(CH_CR);             // answers the waiting empty read
        send_char("Q");               // dropped, line unread
        send_read(6'd0);              // empty, line kept
        send_read(6'd2);
        send_read(6'd63);             // saturates, finishes the line
        send_read(6'd5);
        send_read(6'd63);             // replaces the waiting read
        send_char("h");
        send_char("i");
        send_char(CH_LF);
        send_char("z");
        send_char(CH_LF);
        send_read(6'd1);
        send_read(6'd1);
        send_read(6'd1);

        // Full line: extra characters are dropped, newline still fits
        repeat (300) send_char(random_plain_char());
        send_char(CH_LF);
        repeat (8) send_read(6'd32);

        // Random lines with reads, plus noise, up to the item target
        while (items_sent < ITEM_TARGET) begin
            nogap_mode = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 6)) begin
                    if ($urandom_range(0, 9) < 4)
                        send_read(6'($urandom_range(0, 63)));
                    else
                        send_char(8'($urandom_range(0, 255)));
                end
            end else begin
                early     = ($urandom_range(0, 3) == 0);
                early_cnt = $urandom_range(0, 40);
                if (early)
                    send_read(6'(early_cnt));
                line_chars = 0;
                repeat ($urandom_range(0, 14)) begin
                    r = $urandom_range(0, 19);
                    if (r == 0) begin
                        send_char(CH_BS);
                        if (line_chars > 0)
                            line_chars--;
                    end else if (r == 1) begin
                        send_char(CH_NUL);
                    end else begin
                        send_char(random_plain_char());
                        line_chars++;
                    end
                end
                send_char($urandom_range(0, 1) ? CH_LF : CH_CR);
                remaining = line_chars + 1;
                if (early) begin
                    take = (early_cnt > MAX_READ) ? MAX_READ : early_cnt;
                    remaining -= (take > remaining) ? remaining : take;
                end
                // read the line out in random pieces
                while (remaining > 0) begin
                    if ($urandom_range(0, 9) == 0)
                        send_char(random_plain_char());
                    r = $urandom_range(0, 9);
                    if (r == 0)
                        cnt = 6'd0;
                    else if (r == 1)
                        cnt = 6'($urandom_range(33, 63));
                    else if (r < 4)
                        cnt = 6'($urandom_range(1, 32));
                    else
                        cnt = 6'($urandom_range(1, 8));
                    send_read(cnt);
                    take = (cnt > MAX_READ) ? MAX_READ : cnt;
                    remaining -= (take > remaining) ? remaining : take;
                end
            end
        end
        s_tvalid <= 1'b0;

        // Drain, then let the block settle; the owed count is a registered copy of the queue size
        @(posedge aclk);
        guard = 0;
        while (results_owed != 0 && guard < DRAIN_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (guard < DRAIN_LIMIT && results_owed == 0 && mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
